// ----- sv/image_shift_zoom_resampler_unit_defines.svh -----
// assertion helpers shared by the resampler rtl
`ifndef IMAGE_SHIFT_ZOOM_RESAMPLER_UNIT_DEFINES_SVH
`define IMAGE_SHIFT_ZOOM_RESAMPLER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define ISZ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define ISZ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/isz_pkg.sv -----
`timescale 1ns / 1ps

package isz_pkg;

    localparam int SIDE_DEFAULT = 28;

    localparam int COORD_W = 5;
    localparam int PIX_W = 16;
    localparam int SHIFT_W = 3;
    localparam int ZOOM_W = 15;
    localparam int ZOOM_RESET = 16384;
    localparam int FRAC_W = 15;

    // column, row and pixel packed, padded to whole bytes
    localparam int S_TDATA_W = ((2 * COORD_W + PIX_W + 7) / 8) * 8;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = ZOOM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_ZOOM = 2'd2;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_REQUEST = 1'b1
    } cmd_t;

endpackage

// ----- sv/image_shift_zoom_resampler_unit.sv -----
`timescale 1ns / 1ps
// Nearest-neighbor zoom and shift resampler over one SIDE x SIDE frame held in a
// single-port synchronous RAM. A store transaction (tuser = 0) writes one pixel; a
// request transaction (tuser = 1) maps its output point back through the inverse
// zoom about the frame center, subtracts the shift, rounds half away from zero and
// returns the stored pixel, or zero with m_tuser low when the point falls outside.
// The block takes one transaction per cycle while no result waits on m_tready. The
// two coordinate multiplies are registered at the accepting edge, followed by
// registers for rounding and range check, the address, the RAM read and the
// output register. All stores and reads reach the RAM in arrival order through the
// same port, so a request always sees every store accepted before it. The whole
// pipeline holds while a result waits on m_tready. Configuration writes are always
// ready and should be made only while no transaction is in flight.

`include "image_shift_zoom_resampler_unit_defines.svh"

module image_shift_zoom_resampler_unit #(
    parameter int SIDE = isz_pkg::SIDE_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [4:0] column, [9:5] row, [25:10] pixel_in, rest zero
    input  logic [isz_pkg::S_TDATA_W-1:0]       s_tdata,
    // [0] command
    input  logic [0:0]                          s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] pixel_out
    output logic [isz_pkg::PIX_W-1:0]           m_tdata,
    // [0] source_inside
    output logic [0:0]                          m_tuser,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [isz_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [isz_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int COORD_W = isz_pkg::COORD_W;
    localparam int PIX_W = isz_pkg::PIX_W;
    localparam int FRAC_W = isz_pkg::FRAC_W;
    localparam int ZOOM_W = isz_pkg::ZOOM_W;
    localparam int SHIFT_W = isz_pkg::SHIFT_W;

    localparam int DEPTH = SIDE * SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W = $clog2(SIDE);
    // doubled offset from center, signed
    localparam int OFF_W = $clog2(SIDE + 64) + 1;
    // source coordinate in 2^-15 pixel units, signed
    localparam int N_W = OFF_W + ZOOM_W + 2;
    // rounded magnitude
    localparam int M_W = N_W - FRAC_W;
    localparam int CENTER_TERM = (SIDE - 1) * (2 ** (FRAC_W - 1));
    localparam int HALF = 2 ** (FRAC_W - 1);

    // configuration registers
    logic signed [SHIFT_W-1:0] shift_x_reg;
    logic signed [SHIFT_W-1:0] shift_y_reg;
    logic [ZOOM_W-1:0]         inverse_zoom_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            inverse_zoom_reg <= ZOOM_W'(isz_pkg::ZOOM_RESET);
        end else if (cfg_valid) begin
            if (cfg_index == isz_pkg::CFG_SHIFT_X) begin
                shift_x_reg <= $signed(cfg_data[SHIFT_W-1:0]);
            end else if (cfg_index == isz_pkg::CFG_SHIFT_Y) begin
                shift_y_reg <= $signed(cfg_data[SHIFT_W-1:0]);
            end else if (cfg_index == isz_pkg::CFG_INVERSE_ZOOM) begin
                inverse_zoom_reg <= cfg_data[ZOOM_W-1:0];
            end
        end
    end

    // the pipeline moves as a whole whenever the output register can take a result
    logic advance;
    logic m_valid_reg;

    assign advance = !m_valid_reg || m_tready;
    assign s_tready = advance;

    // input fields
    isz_pkg::cmd_t       in_cmd;
    logic [COORD_W-1:0]  in_col;
    logic [COORD_W-1:0]  in_row;
    logic [PIX_W-1:0]    in_pix;

    assign in_cmd = isz_pkg::cmd_t'(s_tuser[0]);
    assign in_col = s_tdata[COORD_W-1:0];
    assign in_row = s_tdata[2*COORD_W-1:COORD_W];
    assign in_pix = s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];

    // stage 1: scaled source coordinates
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic signed [N_W-1:0]   zoom_s;
    logic signed [N_W-1:0]   nx_next;
    logic signed [N_W-1:0]   ny_next;

    assign off_x = OFF_W'($signed({1'b0, in_col, 1'b0})) - OFF_W'(SIDE - 1);
    assign off_y = OFF_W'($signed({1'b0, in_row, 1'b0})) - OFF_W'(SIDE - 1);
    assign zoom_s = N_W'($signed({1'b0, inverse_zoom_reg}));
    assign nx_next = N_W'(off_x) * zoom_s + N_W'(CENTER_TERM) - (N_W'(shift_x_reg) <<< FRAC_W);
    assign ny_next = N_W'(off_y) * zoom_s + N_W'(CENTER_TERM) - (N_W'(shift_y_reg) <<< FRAC_W);

    logic                  st1_valid_reg;
    isz_pkg::cmd_t         st1_cmd_reg;
    logic [COORD_W-1:0]    st1_col_reg;
    logic [COORD_W-1:0]    st1_row_reg;
    logic [PIX_W-1:0]      st1_pix_reg;
    logic signed [N_W-1:0] st1_nx_reg;
    logic signed [N_W-1:0] st1_ny_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (advance) begin
            st1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_cmd_reg <= in_cmd;
            st1_col_reg <= in_col;
            st1_row_reg <= in_row;
            st1_pix_reg <= in_pix;
            st1_nx_reg <= nx_next;
            st1_ny_reg <= ny_next;
        end
    end

    // round half away from zero, returns {inside, index}; index is zero when outside
    function automatic logic [IDX_W:0] round_coord(input logic signed [N_W-1:0] n);
        logic [N_W-1:0] mag_full;
        logic [N_W-1:0] sum;
        logic [M_W-1:0] mag;
        logic           ok;
        mag_full = n[N_W-1] ? N_W'(-n) : N_W'(n);
        sum = mag_full + N_W'(HALF);
        mag = sum[N_W-1:FRAC_W];
        ok = !(n[N_W-1] && (mag != '0)) && (mag < M_W'(SIDE));
        return {ok, ok ? mag[IDX_W-1:0] : IDX_W'(0)};
    endfunction

    // stage 2: integer source point and range check
    logic [IDX_W:0]     rx;
    logic [IDX_W:0]     ry;
    logic [M_W-1:0]     col_ext;
    logic [M_W-1:0]     row_ext;
    logic               store_ok;
    logic [IDX_W-1:0]   sx_next;
    logic [IDX_W-1:0]   sy_next;
    logic               ok_next;

    assign rx = round_coord(st1_nx_reg);
    assign ry = round_coord(st1_ny_reg);
    assign col_ext = M_W'(st1_col_reg);
    assign row_ext = M_W'(st1_row_reg);
    assign store_ok = (col_ext < M_W'(SIDE)) && (row_ext < M_W'(SIDE));

    always_comb begin
        unique case (st1_cmd_reg)
            isz_pkg::CMD_STORE: begin
                ok_next = store_ok;
                sx_next = store_ok ? col_ext[IDX_W-1:0] : '0;
                sy_next = store_ok ? row_ext[IDX_W-1:0] : '0;
            end
            isz_pkg::CMD_REQUEST: begin
                ok_next = rx[IDX_W] && ry[IDX_W];
                sx_next = ok_next ? rx[IDX_W-1:0] : '0;
                sy_next = ok_next ? ry[IDX_W-1:0] : '0;
            end
            default: begin
                ok_next = 1'b0;
                sx_next = '0;
                sy_next = '0;
            end
        endcase
    end

    logic               st2_valid_reg;
    isz_pkg::cmd_t      st2_cmd_reg;
    logic [IDX_W-1:0]   st2_sx_reg;
    logic [IDX_W-1:0]   st2_sy_reg;
    logic               st2_ok_reg;
    logic [PIX_W-1:0]   st2_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (advance) begin
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st2_cmd_reg <= st1_cmd_reg;
            st2_sx_reg <= sx_next;
            st2_sy_reg <= sy_next;
            st2_ok_reg <= ok_next;
            st2_pix_reg <= st1_pix_reg;
        end
    end

    // stage 3: frame address
    logic [ADDR_W-1:0]  addr_next;

    assign addr_next = ADDR_W'(st2_sy_reg) * ADDR_W'(SIDE) + ADDR_W'(st2_sx_reg);

    logic               st3_valid_reg;
    isz_pkg::cmd_t      st3_cmd_reg;
    logic [ADDR_W-1:0]  st3_addr_reg;
    logic               st3_ok_reg;
    logic [PIX_W-1:0]   st3_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
        end else if (advance) begin
            st3_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st3_cmd_reg <= st2_cmd_reg;
            st3_addr_reg <= addr_next;
            st3_ok_reg <= st2_ok_reg;
            st3_pix_reg <= st2_pix_reg;
        end
    end

    // frame RAM: one access per cycle while the pipeline advances, in arrival order
    logic [PIX_W-1:0] frame_mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (advance && st3_valid_reg) begin
            if (st3_cmd_reg == isz_pkg::CMD_STORE) begin
                if (st3_ok_reg) begin
                    frame_mem[st3_addr_reg] <= st3_pix_reg;
                end
            end else begin
                rd_data_reg <= frame_mem[st3_addr_reg];
            end
        end
    end

    // stage 4: read data valid, requests only
    logic st4_valid_reg;
    logic st4_inside_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st4_valid_reg <= 1'b0;
        end else if (advance) begin
            st4_valid_reg <= st3_valid_reg && (st3_cmd_reg == isz_pkg::CMD_REQUEST);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st4_inside_reg <= st3_ok_reg;
        end
    end

    // output register
    logic [PIX_W-1:0] out_pixel_reg;
    logic             out_inside_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= st4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_pixel_reg <= st4_inside_reg ? rd_data_reg : '0;
            out_inside_reg <= st4_inside_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = out_pixel_reg;
    assign m_tuser = out_inside_reg;

    `ISZ_ASSERT_NOW(a_outside_is_zero, m_tvalid && !m_tuser[0], m_tdata == '0,
        "result outside the frame carries a nonzero pixel")
    `ISZ_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready,
        "input taken while a result is stalled")
    `ISZ_ASSERT_NEXT(a_request_reaches_out,
        advance && st3_valid_reg && (st3_cmd_reg == isz_pkg::CMD_REQUEST), st4_valid_reg,
        "request lost at the frame RAM")
    `ISZ_ASSERT_NEXT(a_store_gives_nothing,
        advance && !(st3_valid_reg && (st3_cmd_reg == isz_pkg::CMD_REQUEST)), !st4_valid_reg,
        "result raised without a request")

endmodule

// ----- test/image_shift_zoom_resampler_unit_tb.sv -----
`timescale 1ns / 1ps

module image_shift_zoom_resampler_unit_tb;

    localparam int SIDE = isz_pkg::SIDE_DEFAULT;
    localparam logic [isz_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint ROUND_HALF = longint'(1) << (isz_pkg::FRAC_W - 1);
    localparam longint ONE_PIXEL = longint'(1) << isz_pkg::FRAC_W;
    localparam int SETTLE_CYCLES = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        isz_pkg::cmd_t                  cmd;
        logic [isz_pkg::COORD_W-1:0]    column;
        logic [isz_pkg::COORD_W-1:0]    row;
        logic [isz_pkg::PIX_W-1:0]      pixel;
    } pixel_txn_t;

    typedef struct packed {
        logic [isz_pkg::PIX_W-1:0]      pixel;
        logic                           in_frame;
    } warped_pixel_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [isz_pkg::S_TDATA_W-1:0]      s_tdata = '0;
    logic [0:0]                         s_tuser = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [isz_pkg::PIX_W-1:0]          m_tdata;
    logic [0:0]                         m_tuser;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [isz_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [isz_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // predictor state
    logic signed [isz_pkg::SHIFT_W-1:0] model_shift_x = '0;
    logic signed [isz_pkg::SHIFT_W-1:0] model_shift_y = '0;
    logic [isz_pkg::ZOOM_W-1:0]         model_zoom = isz_pkg::ZOOM_RESET;
    logic [isz_pkg::PIX_W-1:0]          frame_model [SIDE*SIDE];
    // entries that some queued store has written, tracked at generation time
    bit                                 loaded [SIDE*SIDE];

    pixel_txn_t                         pending_txns [$];
    warped_pixel_t                      expected_pixels [$];
    pixel_txn_t                         driven_txn;
    int                                 txns_queued = 0;
    int                                 txns_accepted = 0;
    int                                 mismatches = 0;
    int                                 gap_left = 0;
    int                                 stall_left = 0;
    int                                 idle_cycles = 0;
    bit                                 sender_gaps = 1'b1;
    bit                                 sink_stalls = 1'b1;

    image_shift_zoom_resampler_unit #(
        .SIDE(SIDE)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // source coordinate in whole pixels, rounded half away from zero
    function automatic longint source_coord(input logic [isz_pkg::COORD_W-1:0] p,
                                            input logic signed [isz_pkg::SHIFT_W-1:0] shift,
                                            input logic [isz_pkg::ZOOM_W-1:0] zoom);
        longint off2;
        longint n;
        off2 = 2 * longint'(p) - (SIDE - 1);
        n = off2 * longint'(zoom) + longint'(SIDE - 1) * ROUND_HALF
            - longint'(shift) * ONE_PIXEL;
        if (n >= 0) return (n + ROUND_HALF) >>> isz_pkg::FRAC_W;
        return -((-n + ROUND_HALF) >>> isz_pkg::FRAC_W);
    endfunction

    function automatic void resample_predict(input pixel_txn_t txn);
        longint sx;
        longint sy;
        warped_pixel_t want;
        if (txn.cmd == isz_pkg::CMD_STORE) begin
            if (txn.column < SIDE && txn.row < SIDE)
                frame_model[txn.row * SIDE + txn.column] = txn.pixel;
            return;
        end
        sx = source_coord(txn.column, model_shift_x, model_zoom);
        sy = source_coord(txn.row, model_shift_y, model_zoom);
        if (sx >= 0 && sx < SIDE && sy >= 0 && sy < SIDE) begin
            want.pixel = frame_model[sy * SIDE + sx];
            want.in_frame = 1'b1;
        end else begin
            want.pixel = '0;
            want.in_frame = 1'b0;
        end
        expected_pixels = {expected_pixels, want};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void queue_store(input int column, input int row, input int pixel);
        pixel_txn_t txn;
        txn.cmd = isz_pkg::CMD_STORE;
        txn.column = column[isz_pkg::COORD_W-1:0];
        txn.row = row[isz_pkg::COORD_W-1:0];
        txn.pixel = pixel[isz_pkg::PIX_W-1:0];
        if (txn.column < SIDE && txn.row < SIDE) loaded[txn.row * SIDE + txn.column] = 1'b1;
        pending_txns = {pending_txns, txn};
        txns_queued++;
    endfunction

    // a request whose source is an unwritten entry gets a store there first
    function automatic void queue_request(input int column, input int row);
        pixel_txn_t txn;
        longint sx;
        longint sy;
        txn.cmd = isz_pkg::CMD_REQUEST;
        txn.column = column[isz_pkg::COORD_W-1:0];
        txn.row = row[isz_pkg::COORD_W-1:0];
        txn.pixel = isz_pkg::PIX_W'($urandom);
        sx = source_coord(txn.column, model_shift_x, model_zoom);
        sy = source_coord(txn.row, model_shift_y, model_zoom);
        if (sx >= 0 && sx < SIDE && sy >= 0 && sy < SIDE && !loaded[sy * SIDE + sx])
            queue_store(int'(sx), int'(sy), $urandom_range(0, 65535));
        pending_txns = {pending_txns, txn};
        txns_queued++;
    endfunction

    function automatic void queue_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                queue_store($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                            $urandom_range(0, 65535));
            else if (r < 50)
                queue_store($urandom_range(SIDE, 31), $urandom_range(0, 31),
                            $urandom_range(0, 65535));
            else if (r < 92)
                queue_request($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1));
            else
                queue_request($urandom_range(0, 31), $urandom_range(0, 31));
        end
    endfunction

    task automatic write_register(input logic [isz_pkg::CFG_IDX_W-1:0] index,
                                  input logic [isz_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            isz_pkg::CFG_SHIFT_X: model_shift_x = value[isz_pkg::SHIFT_W-1:0];
            isz_pkg::CFG_SHIFT_Y: model_shift_y = value[isz_pkg::SHIFT_W-1:0];
            isz_pkg::CFG_INVERSE_ZOOM: model_zoom = value[isz_pkg::ZOOM_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_warp(input int shift_x, input int shift_y, input int zoom);
        write_register(isz_pkg::CFG_SHIFT_X, isz_pkg::CFG_DATA_W'(shift_x));
        write_register(isz_pkg::CFG_SHIFT_Y, isz_pkg::CFG_DATA_W'(shift_y));
        write_register(isz_pkg::CFG_INVERSE_ZOOM, isz_pkg::CFG_DATA_W'(zoom));
    endtask

    // stores leave no result, so let the pipeline empty after the last one
    task automatic wait_until_drained();
        while (txns_accepted != txns_queued || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        logic [isz_pkg::S_TDATA_W-1:0] word;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                resample_predict(driven_txn);
                txns_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_txns.size() > 0) begin
                    driven_txn = pending_txns.pop_front();
                    word = '0;
                    word[isz_pkg::COORD_W-1:0] = driven_txn.column;
                    word[2*isz_pkg::COORD_W-1:isz_pkg::COORD_W] = driven_txn.row;
                    word[2*isz_pkg::COORD_W+isz_pkg::PIX_W-1:2*isz_pkg::COORD_W] =
                        driven_txn.pixel;
                    s_tvalid <= 1'b1;
                    s_tdata <= word;
                    s_tuser <= driven_txn.cmd;
                    gap_left = sender_gaps ? pick_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        warped_pixel_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected result pixel_out=%0d source_inside=%0d",
                                              m_tdata, m_tuser));
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata !== want.pixel)
                        report_mismatch($sformatf("pixel_out got %0d expected %0d",
                                                  m_tdata, want.pixel));
                    if (m_tuser[0] !== want.in_frame)
                        report_mismatch($sformatf("source_inside got %0d expected %0d",
                                                  m_tuser, want.in_frame));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap() + 1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("image_shift_zoom_resampler_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings map every point onto itself
        queue_store(0, 0, 0);
        queue_store(SIDE - 1, 0, 65535);
        queue_store(0, SIDE - 1, 16'h5555);
        queue_store(SIDE - 1, SIDE - 1, 16'hAAAA);
        queue_store(13, 14, 16'h1234);
        queue_store(31, 31, 16'hFFFF);
        queue_store(SIDE, 3, 7);
        queue_store(3, SIDE, 9);
        queue_request(0, 0);
        queue_request(SIDE - 1, 0);
        queue_request(0, SIDE - 1);
        queue_request(SIDE - 1, SIDE - 1);
        queue_request(13, 14);
        queue_request(14, 13);
        queue_request(31, 31);
        queue_request(SIDE, 0);
        queue_request(0, SIDE);
        queue_request(SIDE - 1, 31);
        // overwrite then read back in the same stream
        queue_store(0, 0, 16'hFFFF);
        queue_request(0, 0);
        wait_until_drained();

        queue_random(220);
        wait_until_drained();

        // unused index must leave every register alone
        write_register(CFG_UNUSED, 15'h7FFF);
        set_warp(-2, -2, 14895);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        queue_random(220);
        wait_until_drained();

        set_warp(2, 2, 18204);
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        queue_random(110);
        wait_until_drained();
        queue_random(110);
        wait_until_drained();

        set_warp(-4, 3, 32767);
        queue_random(150);
        wait_until_drained();

        set_warp(3, -4, 0);
        queue_random(150);
        wait_until_drained();

        for (int p = 0; p < 2; p++) begin
            set_warp($urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2,
                     $urandom_range(14895, 18204));
            sender_gaps = $urandom_range(0, 1);
            sink_stalls = $urandom_range(0, 1);
            queue_random(220);
            wait_until_drained();
        end

        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
        if (mismatches == 0) begin
            $display("image_shift_zoom_resampler_unit regression: pass");
        end else begin
            $display("image_shift_zoom_resampler_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/isz_pkg.sv
sv/image_shift_zoom_resampler_unit.sv
test/image_shift_zoom_resampler_unit_tb.sv
